// ----- rtl/core/cabac_pkg.sv -----
// Shared types, field widths, item codes and decoding tables for the CABAC decoder core.
// No dependencies; imported by cabac_binary_arithmetic_decoder_core.
package cabac_pkg;

    localparam int KIND_W      = 3;
    localparam int CTX_INDEX_W = 10;
    localparam int STATE_W     = 6;
    localparam int RANGE_W     = 9;
    localparam int VALUE_W     = 26;
    localparam int BITS_W      = 5;
    localparam int WORD_W      = 24;
    localparam int BYTES_W     = 2;
    localparam int SHIFT_W     = 3;
    // widest threshold: a 9-bit range shifted by up to 31
    localparam int THR_W       = RANGE_W + 31;
    localparam int CTX_W       = STATE_W + 1;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_START     = 3'd0;
    localparam t_kind KIND_LOAD      = 3'd1;
    localparam t_kind KIND_DECISION  = 3'd2;
    localparam t_kind KIND_BYPASS    = 3'd3;
    localparam t_kind KIND_TERMINATE = 3'd4;

    localparam logic [RANGE_W-1:0] RANGE_RESET     = 9'd510;
    localparam logic [BITS_W-1:0]  BITS_LEFT_RESET = 5'd15;
    localparam logic [BITS_W-1:0]  REFILL_BITS     = 5'd16;
    localparam logic [RANGE_W-1:0] TERM_RANGE_DEC  = 9'd2;

    localparam logic [BYTES_W-1:0] BYTES_NONE   = 2'd0;
    localparam logic [BYTES_W-1:0] BYTES_REFILL = 2'd2;
    localparam logic [BYTES_W-1:0] BYTES_START  = 2'd3;

    typedef struct packed {
        logic               mps;
        logic [STATE_W-1:0] state;
    } t_ctx;

    typedef struct packed {
        logic [RANGE_W-1:0] range;
        logic [VALUE_W-1:0] value;
        logic [BITS_W-1:0]  bits_left;
    } t_eng;

    typedef struct packed {
        t_eng eng;
        logic refilled;
    } t_renorm;

    localparam logic [0:63][0:3][7:0] LPS_TAB = '{
        '{8'd128,8'd176,8'd208,8'd240}, '{8'd128,8'd167,8'd197,8'd227},
        '{8'd128,8'd158,8'd187,8'd216}, '{8'd123,8'd150,8'd178,8'd205},
        '{8'd116,8'd142,8'd169,8'd195}, '{8'd111,8'd135,8'd160,8'd185},
        '{8'd105,8'd128,8'd152,8'd175}, '{8'd100,8'd122,8'd144,8'd166},
        '{8'd95, 8'd116,8'd137,8'd158}, '{8'd90, 8'd110,8'd130,8'd150},
        '{8'd85, 8'd104,8'd123,8'd142}, '{8'd81, 8'd99, 8'd117,8'd135},
        '{8'd77, 8'd94, 8'd111,8'd128}, '{8'd73, 8'd89, 8'd105,8'd122},
        '{8'd69, 8'd85, 8'd100,8'd116}, '{8'd66, 8'd80, 8'd95, 8'd110},
        '{8'd62, 8'd76, 8'd90, 8'd104}, '{8'd59, 8'd72, 8'd86, 8'd99},
        '{8'd56, 8'd69, 8'd81, 8'd94},  '{8'd53, 8'd65, 8'd77, 8'd89},
        '{8'd51, 8'd62, 8'd73, 8'd85},  '{8'd48, 8'd59, 8'd69, 8'd80},
        '{8'd46, 8'd56, 8'd66, 8'd76},  '{8'd43, 8'd53, 8'd63, 8'd72},
        '{8'd41, 8'd50, 8'd59, 8'd69},  '{8'd39, 8'd48, 8'd56, 8'd65},
        '{8'd37, 8'd45, 8'd54, 8'd62},  '{8'd35, 8'd43, 8'd51, 8'd59},
        '{8'd33, 8'd41, 8'd48, 8'd56},  '{8'd32, 8'd39, 8'd46, 8'd53},
        '{8'd30, 8'd37, 8'd43, 8'd50},  '{8'd29, 8'd35, 8'd41, 8'd48},
        '{8'd27, 8'd33, 8'd39, 8'd45},  '{8'd26, 8'd31, 8'd37, 8'd43},
        '{8'd24, 8'd30, 8'd35, 8'd41},  '{8'd23, 8'd28, 8'd33, 8'd39},
        '{8'd22, 8'd27, 8'd32, 8'd37},  '{8'd21, 8'd26, 8'd30, 8'd35},
        '{8'd20, 8'd24, 8'd29, 8'd33},  '{8'd19, 8'd23, 8'd27, 8'd31},
        '{8'd18, 8'd22, 8'd26, 8'd30},  '{8'd17, 8'd21, 8'd25, 8'd28},
        '{8'd16, 8'd20, 8'd23, 8'd27},  '{8'd15, 8'd19, 8'd22, 8'd25},
        '{8'd14, 8'd18, 8'd21, 8'd24},  '{8'd14, 8'd17, 8'd20, 8'd23},
        '{8'd13, 8'd16, 8'd19, 8'd22},  '{8'd12, 8'd15, 8'd18, 8'd21},
        '{8'd12, 8'd14, 8'd17, 8'd20},  '{8'd11, 8'd14, 8'd16, 8'd19},
        '{8'd11, 8'd13, 8'd15, 8'd18},  '{8'd10, 8'd12, 8'd15, 8'd17},
        '{8'd10, 8'd12, 8'd14, 8'd16},  '{8'd9,  8'd11, 8'd13, 8'd15},
        '{8'd9,  8'd11, 8'd12, 8'd14},  '{8'd8,  8'd10, 8'd12, 8'd14},
        '{8'd8,  8'd9,  8'd11, 8'd13},  '{8'd7,  8'd9,  8'd11, 8'd12},
        '{8'd7,  8'd9,  8'd10, 8'd12},  '{8'd7,  8'd8,  8'd10, 8'd11},
        '{8'd6,  8'd8,  8'd9,  8'd11},  '{8'd6,  8'd7,  8'd9,  8'd10},
        '{8'd6,  8'd7,  8'd8,  8'd9},   '{8'd2,  8'd2,  8'd2,  8'd2}
    };

    localparam logic [0:63][STATE_W-1:0] NEXT_LPS_TAB = '{
        6'd0, 6'd0, 6'd1, 6'd2, 6'd2, 6'd4, 6'd4, 6'd5,
        6'd6, 6'd7, 6'd8, 6'd9, 6'd9, 6'd11,6'd11,6'd12,
        6'd13,6'd13,6'd15,6'd15,6'd16,6'd16,6'd18,6'd18,
        6'd19,6'd19,6'd21,6'd21,6'd22,6'd22,6'd23,6'd24,
        6'd24,6'd25,6'd26,6'd26,6'd27,6'd27,6'd28,6'd29,
        6'd29,6'd30,6'd30,6'd30,6'd31,6'd32,6'd32,6'd33,
        6'd33,6'd33,6'd34,6'd34,6'd35,6'd35,6'd35,6'd36,
        6'd36,6'd36,6'd37,6'd37,6'd37,6'd38,6'd38,6'd63
    };

    localparam logic [0:63][STATE_W-1:0] NEXT_MPS_TAB = '{
        6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8,
        6'd9, 6'd10,6'd11,6'd12,6'd13,6'd14,6'd15,6'd16,
        6'd17,6'd18,6'd19,6'd20,6'd21,6'd22,6'd23,6'd24,
        6'd25,6'd26,6'd27,6'd28,6'd29,6'd30,6'd31,6'd32,
        6'd33,6'd34,6'd35,6'd36,6'd37,6'd38,6'd39,6'd40,
        6'd41,6'd42,6'd43,6'd44,6'd45,6'd46,6'd47,6'd48,
        6'd49,6'd50,6'd51,6'd52,6'd53,6'd54,6'd55,6'd56,
        6'd57,6'd58,6'd59,6'd60,6'd61,6'd62,6'd62,6'd63
    };

    // renormalization shift indexed by range bits 7..3
    localparam logic [0:31][SHIFT_W-1:0] RENORM_SHIFT_TAB = '{
        3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1
    };

endpackage

// ----- rtl/core/cabac_binary_arithmetic_decoder_core.sv -----
// CABAC binary arithmetic decoding engine with a context store RAM.
// Depends on cabac_pkg and cabac_ram.
// Result path: an accepted item passes the stage 1 register and then the output register,
// where o_valid rises; the result transfers when the consumer takes it.
// Throughput: one item per cycle unless the output register is full and i_ready is low; set by
// the engine update in stage 1, which reads range, offset and bit count written by the item before it.
// Reset (i_rst_n low, synchronous): pipeline and output emptied, range 510, offset 0,
// bit count 15. The context RAM is not cleared; entries hold garbage until loaded.
module cabac_binary_arithmetic_decoder_core #(
    parameter int NUM_CONTEXTS = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // item channel
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [cabac_pkg::KIND_W-1:0]          i_kind,
    input  logic [cabac_pkg::CTX_INDEX_W-1:0]     i_context_index,
    input  logic [cabac_pkg::STATE_W-1:0]         i_load_state,
    input  logic                                  i_load_mps,
    input  logic [cabac_pkg::WORD_W-1:0]          i_code_word,
    // result channel
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_bin,
    output logic [cabac_pkg::BYTES_W-1:0]         o_bytes_consumed
);

    import cabac_pkg::*;

    localparam int ADDR_W = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam bit IS_POW2 = ((NUM_CONTEXTS & (NUM_CONTEXTS - 1)) == 0);
    // index reduction by reciprocal: q = (idx * RED_MUL) >> RED_SHIFT is exact for 10-bit idx
    localparam int RED_SHIFT = CTX_INDEX_W + ADDR_W;
    localparam int RED_MUL_I = ((1 << RED_SHIFT) + NUM_CONTEXTS - 1) / NUM_CONTEXTS;
    localparam int PROD_W    = 2 * CTX_INDEX_W + 1;

    // ------------------------------------------------------------------
    // Pipeline control
    //   stage 0: input transfer, context RAM read issued
    //   stage 1: context word available, engine update, RAM write back
    //   output register: result waits here for the consumer
    // ------------------------------------------------------------------
    logic              r_s1_valid;
    logic              r_out_valid;
    logic              s1_advance;
    logic              in_accept;

    assign s1_advance = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready    = !r_s1_valid || s1_advance;
    assign in_accept  = i_valid && o_ready;

    // ------------------------------------------------------------------
    // Context index wrap into the store
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] in_addr;

    generate
        if (NUM_CONTEXTS == 1) begin : g_addr_one
            assign in_addr = '0;
        end else if (IS_POW2) begin : g_addr_pow2
            assign in_addr = i_context_index[ADDR_W-1:0];
        end else begin : g_addr_recip
            localparam logic [PROD_W-1:0] RED_MUL = PROD_W'(RED_MUL_I);
            logic [PROD_W-1:0]        red_prod;
            logic [CTX_INDEX_W-1:0]   red_quot;
            logic [PROD_W-1:0]        red_back;
            logic [CTX_INDEX_W-1:0]   red_rem;

            assign red_prod = PROD_W'({{(PROD_W-CTX_INDEX_W){1'b0}}, i_context_index} * RED_MUL);
            assign red_quot = CTX_INDEX_W'(red_prod >> RED_SHIFT);
            // constant multiply by the store depth, then subtract back
            assign red_back = PROD_W'({{(PROD_W-CTX_INDEX_W){1'b0}}, red_quot}
                              * PROD_W'(NUM_CONTEXTS));
            assign red_rem  = i_context_index - red_back[CTX_INDEX_W-1:0];
            assign in_addr  = red_rem[ADDR_W-1:0];
        end
    endgenerate

    // ------------------------------------------------------------------
    // Context store
    // ------------------------------------------------------------------
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    t_ctx              ram_wr_data;
    logic [CTX_W-1:0]  ram_rd_data;

    cabac_ram #(
        .WIDTH (CTX_W),
        .DEPTH (NUM_CONTEXTS)
    ) u_ctx_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (in_accept),
        .i_rd_addr (in_addr),
        .o_rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Stage 1 registers
    // ------------------------------------------------------------------
    t_kind              r_s1_kind;
    logic [ADDR_W-1:0]  r_s1_addr;
    t_ctx               r_s1_load;
    logic [WORD_W-1:0]  r_s1_word;
    logic               r_s1_fwd;       // RAM read raced a write to the same entry
    t_ctx               r_s1_fwd_data;
    logic               n_s1_fwd;

    // Engine state
    t_eng               r_eng;
    t_eng               n_eng;

    // Output register
    logic               r_out_bin;
    logic [BYTES_W-1:0] r_out_bytes;
    logic               n_bin;
    logic [BYTES_W-1:0] n_bytes;

    t_ctx               s1_ctx;
    logic               s1_ctx_wr;
    t_ctx               s1_ctx_new;

    // The write of the item leaving stage 1 lands at the same edge the next item reads;
    // the RAM returns the old word then, so bypass the new one.
    assign n_s1_fwd = ram_wr_en && in_accept && (ram_wr_addr == in_addr);
    assign s1_ctx   = r_s1_fwd ? r_s1_fwd_data : t_ctx'(ram_rd_data);

    assign ram_wr_en   = s1_advance && s1_ctx_wr;
    assign ram_wr_addr = r_s1_addr;
    assign ram_wr_data = s1_ctx_new;

    // ------------------------------------------------------------------
    // Engine arithmetic
    // ------------------------------------------------------------------
    function automatic logic [THR_W-1:0] f_threshold(input logic [RANGE_W-1:0] range,
                                                     input logic [BITS_W-1:0]  bits);
        return {{(THR_W-RANGE_W){1'b0}}, range} << bits;
    endfunction

    function automatic logic [VALUE_W-1:0] f_refill(input logic [VALUE_W-1:0] value,
                                                    input logic [WORD_W-1:0]  word);
        // shift in the first two stream bytes, keep 26 bits
        return {value[VALUE_W-17:0], word[WORD_W-1:8]};
    endfunction

    function automatic t_renorm f_renorm(input t_eng eng, input logic [WORD_W-1:0] word);
        t_renorm            res;
        logic [SHIFT_W-1:0] sh;
        logic signed [6:0]  left;
        res          = '{eng: eng, refilled: 1'b0};
        sh           = '0;
        left         = '0;
        if (!eng.range[RANGE_W-1]) begin
            sh                = RENORM_SHIFT_TAB[eng.range[7:3]];
            res.eng.range     = RANGE_W'(eng.range << sh);
            left              = $signed({2'b00, eng.bits_left}) - $signed({4'b0000, sh});
            if (left <= 7'sd0) begin
                res.eng.value = f_refill(eng.value, word);
                left          = left + 7'sd16;
                res.refilled  = 1'b1;
            end
            res.eng.bits_left = left[BITS_W-1:0];
        end
        return res;
    endfunction

    always_comb begin
        logic [7:0]         lps;
        logic [RANGE_W-1:0] range_mps;
        logic [THR_W-1:0]   thr;
        t_eng               mid;
        t_renorm            rn;

        lps        = LPS_TAB[s1_ctx.state][r_eng.range[7:6]];
        range_mps  = r_eng.range - {1'b0, lps};
        thr        = '0;
        mid        = r_eng;
        rn         = '{eng: r_eng, refilled: 1'b0};
        n_eng      = r_eng;
        n_bin      = 1'b0;
        n_bytes    = BYTES_NONE;
        s1_ctx_wr  = 1'b0;
        s1_ctx_new = s1_ctx;

        case (r_s1_kind)
            KIND_START: begin
                n_eng.value     = {{(VALUE_W-WORD_W){1'b0}}, r_s1_word};
                n_eng.range     = RANGE_RESET;
                n_eng.bits_left = BITS_LEFT_RESET;
                n_bytes         = BYTES_START;
            end
            KIND_LOAD: begin
                s1_ctx_wr  = 1'b1;
                s1_ctx_new = r_s1_load;
            end
            KIND_DECISION: begin
                s1_ctx_wr = 1'b1;
                thr       = f_threshold(range_mps, r_eng.bits_left);
                if ({{(THR_W-VALUE_W){1'b0}}, r_eng.value} < thr) begin
                    // most probable path
                    n_bin            = s1_ctx.mps;
                    mid.range        = range_mps;
                    s1_ctx_new.state = NEXT_MPS_TAB[s1_ctx.state];
                end else begin
                    n_bin            = ~s1_ctx.mps;
                    mid.value        = r_eng.value - thr[VALUE_W-1:0];
                    mid.range        = {1'b0, lps};
                    s1_ctx_new.mps   = (s1_ctx.state == '0) ? ~s1_ctx.mps : s1_ctx.mps;
                    s1_ctx_new.state = NEXT_LPS_TAB[s1_ctx.state];
                end
                rn    = f_renorm(mid, r_s1_word);
                n_eng = rn.eng;
                if (rn.refilled) begin
                    n_bytes = BYTES_REFILL;
                end
            end
            KIND_BYPASS: begin
                mid.bits_left = r_eng.bits_left - 5'd1;
                if (mid.bits_left == '0) begin
                    mid.value     = f_refill(r_eng.value, r_s1_word);
                    mid.bits_left = REFILL_BITS;
                    n_bytes       = BYTES_REFILL;
                end
                thr = f_threshold(r_eng.range, mid.bits_left);
                if ({{(THR_W-VALUE_W){1'b0}}, mid.value} >= thr) begin
                    n_bin     = 1'b1;
                    mid.value = mid.value - thr[VALUE_W-1:0];
                end
                n_eng = mid;
            end
            KIND_TERMINATE: begin
                mid.range = r_eng.range - TERM_RANGE_DEC;
                thr       = f_threshold(mid.range, r_eng.bits_left);
                if ({{(THR_W-VALUE_W){1'b0}}, r_eng.value} < thr) begin
                    rn    = f_renorm(mid, r_s1_word);
                    n_eng = rn.eng;
                    if (rn.refilled) begin
                        n_bytes = BYTES_REFILL;
                    end
                end else begin
                    // end of slice: no renormalization
                    n_bin = 1'b1;
                    n_eng = mid;
                end
            end
            default: begin
                // unused kinds: result of zero, state untouched
                n_eng = r_eng;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid      <= 1'b0;
            r_s1_fwd        <= 1'b0;
            r_out_valid     <= 1'b0;
            r_eng.range     <= RANGE_RESET;
            r_eng.value     <= '0;
            r_eng.bits_left <= BITS_LEFT_RESET;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (in_accept || s1_advance) begin
                r_s1_fwd <= n_s1_fwd;
            end
            if (s1_advance) begin
                r_out_valid <= 1'b1;
                r_eng       <= n_eng;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_kind     <= i_kind;
            r_s1_addr     <= in_addr;
            r_s1_load     <= '{mps: i_load_mps, state: i_load_state};
            r_s1_word     <= i_code_word;
            r_s1_fwd_data <= ram_wr_data;
        end
        if (s1_advance) begin
            r_out_bin   <= n_bin;
            r_out_bytes <= n_bytes;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_bin            = r_out_bin;
    assign o_bytes_consumed = r_out_bytes;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_bits_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_eng.bits_left != '0) && (r_eng.bits_left <= REFILL_BITS))
        else $error("bit count left its legal range");

    a_fwd_needs_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_fwd |-> r_s1_valid)
        else $error("bypass flag set with stage 1 empty");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_s1_valid && r_out_valid && !i_ready))
        else $error("input stalled while pipeline had room");

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_advance |=> r_out_valid)
        else $error("stage 1 transfer lost");

    a_start_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_advance && (r_s1_kind == KIND_START)) |=>
            ((r_out_bytes == BYTES_START) && (r_eng.range == RANGE_RESET)))
        else $error("start item did not reload the engine");

endmodule

// ----- rtl/core/cabac_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies; read of an address written at the same edge returns the old data.
module cabac_ram #(
    parameter int WIDTH  = 7,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        // hold the last read word while no read is issued
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
